// ===== hw/rtl/bto_pkg.sv =====
// ----------------------------------------------------------------------------
// bto_pkg
// Shared types and constants for the binomial tree option pricer.
// ----------------------------------------------------------------------------
package bto_pkg;

    localparam int MAX_STEPS = 1024;
    localparam int ROW_DEPTH = MAX_STEPS + 1;
    localparam int IDX_W     = $clog2(ROW_DEPTH);
    localparam int PRICE_W   = 32;
    localparam int PROB_W    = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);
    localparam logic [IDX_W-1:0]  STEPS_MAX = IDX_W'(MAX_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPOT     = 3'd0,
        CFG_UP       = 3'd1,
        CFG_DOWN     = 3'd2,
        CFG_PROB     = 3'd3,
        CFG_DISC     = 3'd4,
        CFG_STEPS    = 3'd5,
        CFG_IS_CALL  = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEAF_INIT,
        ST_LEAF_MUL,
        ST_LEAF_RND,
        ST_LEAF_WR,
        ST_RDA,
        ST_RDA_W,
        ST_RDB,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/bto_if.sv =====
// ----------------------------------------------------------------------------
// bto_if
// Request and result channels of the option pricer.
// ----------------------------------------------------------------------------
interface bto_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] strike;
    modport source (output valid, output strike, input ready);
    modport sink   (input valid, input strike, output ready);
endinterface

interface bto_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] option_value;
    modport source (output valid, output option_value, input ready);
    modport sink   (input valid, input option_value, output ready);
endinterface

// ===== hw/rtl/bto_mul.sv =====
// ----------------------------------------------------------------------------
// bto_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module bto_mul (
    input  logic        clk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod_reg
);

    logic [63:0] prod_next;

    assign prod_next = {32'd0, op_a} * {32'd0, op_b};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== hw/rtl/bto_ram.sv =====
// ----------------------------------------------------------------------------
// bto_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bto_ram #(
    parameter int DEPTH = 1025,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/binomial_tree_option_pricer.sv =====
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer
// European option value from a binomial tree, one shared multiplier.
// ----------------------------------------------------------------------------
// channel   dir   handshake     payload
// request   in    valid/ready   strike        (Q16.16)
// result    out   valid/ready   option_value  (Q16.16)
// cfg       in    cfg_we        cfg_index, cfg_data
//
// one request prices n+1 leaves, then folds the tree row by row, n = steps,
// all on the single multiplier: each leaf multiply passes LEAF_MUL and LEAF_RND, each tree node RDB and M1 to M6
// ready is high only when idle; the result holds until taken
// reset clears the state and config registers; datapath registers and the row memory are not cleared
module binomial_tree_option_pricer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bto_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    bto_req_if.sink                       request,
    bto_res_if.source                     result
);

    localparam int IW = bto_pkg::IDX_W;

    bto_pkg::state_t state_reg, state_next;

    logic [31:0] spot_reg, up_reg, down_reg;
    logic [16:0] prob_reg, disc_cfg_reg;
    logic [10:0] steps_reg;
    logic        call_reg;

    logic [31:0] strike_reg, strike_next;
    logic [IW-1:0] n_reg, n_next;
    logic [16:0] pu_reg, pu_next, pd_reg, pd_next, disc_reg, disc_next;
    logic        leaf_call_reg, leaf_call_next;
    logic [IW-1:0] j_reg, j_next, k_reg, k_next, i_reg, i_next;
    logic [31:0] p_reg, p_next, a_reg, a_next, b_reg, b_next;
    logic [48:0] acc_reg, acc_next;
    logic [63:0] acc2_reg, acc2_next;
    logic [31:0] out_reg, out_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;
    logic        ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, rdata_reg;

    logic [64:0] rnd_sum;
    logic [31:0] p_sat, payoff;
    logic [63:0] node_sum;
    logic [IW-1:0] n_clamp;

    bto_mul u_mul (
        .clk      (clk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    bto_ram #(
        .DEPTH (bto_pkg::ROW_DEPTH),
        .WIDTH (32)
    ) u_ram (
        .clk       (clk),
        .we        (ram_we),
        .waddr     (ram_waddr),
        .wdata     (ram_wdata),
        .re        (ram_re),
        .raddr     (ram_raddr),
        .rdata_reg (rdata_reg)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spot_reg     <= 32'd0;
            up_reg       <= 32'd1073741824;
            down_reg     <= 32'd1073741824;
            prob_reg     <= 17'd32768;
            disc_cfg_reg <= 17'd65536;
            steps_reg    <= 11'd1;
            call_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bto_pkg::CFG_SPOT:    spot_reg     <= cfg_data;
                bto_pkg::CFG_UP:      up_reg       <= cfg_data;
                bto_pkg::CFG_DOWN:    down_reg     <= cfg_data;
                bto_pkg::CFG_PROB:    prob_reg     <= cfg_data[16:0];
                bto_pkg::CFG_DISC:    disc_cfg_reg <= cfg_data[16:0];
                bto_pkg::CFG_STEPS:   steps_reg    <= cfg_data[10:0];
                bto_pkg::CFG_IS_CALL: call_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign n_clamp = (steps_reg > 11'(bto_pkg::MAX_STEPS)) ? bto_pkg::STEPS_MAX
                                                            : IW'(steps_reg);

    // rounding of a leaf multiply, saturated to 32 bits
    assign rnd_sum = {1'b0, prod_reg} + 65'(64'd1 << 29);
    assign p_sat   = (rnd_sum[64:62] != 3'd0) ? 32'hFFFF_FFFF : rnd_sum[61:30];
    assign payoff  = leaf_call_reg ? ((p_reg > strike_reg) ? p_reg - strike_reg : 32'd0)
                                   : ((strike_reg > p_reg) ? strike_reg - p_reg : 32'd0);
    assign node_sum = acc2_reg + {prod_reg[31:0], 32'd0} + 64'h8000_0000;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bto_pkg::ST_IDLE:
                if (request.valid) state_next = bto_pkg::ST_LEAF_INIT;
            bto_pkg::ST_LEAF_INIT:
                state_next = (n_reg == '0) ? bto_pkg::ST_LEAF_WR : bto_pkg::ST_LEAF_MUL;
            bto_pkg::ST_LEAF_MUL:
                state_next = bto_pkg::ST_LEAF_RND;
            bto_pkg::ST_LEAF_RND:
                state_next = (k_reg + IW'(1) == n_reg) ? bto_pkg::ST_LEAF_WR
                                                       : bto_pkg::ST_LEAF_MUL;
            bto_pkg::ST_LEAF_WR:
                if (j_reg != n_reg)
                    state_next = bto_pkg::ST_LEAF_INIT;
                else if (n_reg == '0)
                    state_next = bto_pkg::ST_FIN;
                else
                    state_next = bto_pkg::ST_RDA;
            bto_pkg::ST_RDA:   state_next = bto_pkg::ST_RDA_W;
            bto_pkg::ST_RDA_W: state_next = bto_pkg::ST_RDB;
            bto_pkg::ST_RDB:   state_next = bto_pkg::ST_M1;
            bto_pkg::ST_M1:    state_next = bto_pkg::ST_M2;
            bto_pkg::ST_M2:    state_next = bto_pkg::ST_M3;
            bto_pkg::ST_M3:    state_next = bto_pkg::ST_M4;
            bto_pkg::ST_M4:    state_next = bto_pkg::ST_M5;
            bto_pkg::ST_M5:    state_next = bto_pkg::ST_M6;
            bto_pkg::ST_M6:
                if (j_reg + IW'(1) != i_reg)
                    state_next = bto_pkg::ST_RDB;
                else if (i_reg == IW'(1))
                    state_next = bto_pkg::ST_FIN;
                else
                    state_next = bto_pkg::ST_RDA;
            bto_pkg::ST_FIN:   state_next = bto_pkg::ST_RDA_W;
            bto_pkg::ST_DONE:
                if (result.ready) state_next = bto_pkg::ST_IDLE;
            default: state_next = bto_pkg::ST_IDLE;
        endcase
        // the final read reuses the wait state; leave it toward done
        if (state_reg == bto_pkg::ST_RDA_W && i_reg == '0)
            state_next = bto_pkg::ST_DONE;
    end

    // outputs and datapath
    always_comb
    begin
        strike_next    = strike_reg;
        n_next         = n_reg;
        pu_next        = pu_reg;
        pd_next        = pd_reg;
        disc_next      = disc_reg;
        leaf_call_next = leaf_call_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        acc2_next      = acc2_reg;
        out_next       = out_reg;
        mul_a          = p_reg;
        mul_b          = (k_reg < j_reg) ? down_reg : up_reg;
        ram_we         = 1'b0;
        ram_waddr      = j_reg;
        ram_wdata      = payoff;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        unique case (state_reg)
            bto_pkg::ST_IDLE:
                if (request.valid)
                begin
                    strike_next    = request.strike;
                    n_next         = n_clamp;
                    pu_next        = (prob_reg > bto_pkg::PROB_ONE) ? bto_pkg::PROB_ONE
                                                                    : prob_reg;
                    pd_next        = bto_pkg::PROB_ONE - ((prob_reg > bto_pkg::PROB_ONE)
                                                          ? bto_pkg::PROB_ONE : prob_reg);
                    disc_next      = (disc_cfg_reg > bto_pkg::PROB_ONE) ? bto_pkg::PROB_ONE
                                                                        : disc_cfg_reg;
                    leaf_call_next = call_reg;
                    j_next         = '0;
                    i_next         = n_clamp;
                end
            bto_pkg::ST_LEAF_INIT:
            begin
                p_next = spot_reg;
                k_next = '0;
            end
            bto_pkg::ST_LEAF_MUL: ;
            bto_pkg::ST_LEAF_RND:
            begin
                p_next = p_sat;
                k_next = k_reg + IW'(1);
            end
            bto_pkg::ST_LEAF_WR:
            begin
                ram_we = 1'b1;
                if (j_reg != n_reg)
                    j_next = j_reg + IW'(1);
                else
                    j_next = '0;
            end
            bto_pkg::ST_RDA:
                ram_re = 1'b1;
            bto_pkg::ST_RDA_W:
                a_next = rdata_reg;
            bto_pkg::ST_RDB:
            begin
                ram_re    = 1'b1;
                ram_raddr = j_reg + IW'(1);
            end
            bto_pkg::ST_M1:
            begin
                b_next = rdata_reg;
                mul_a  = a_reg;
                mul_b  = {15'd0, pu_reg};
            end
            bto_pkg::ST_M2:
            begin
                acc_next = prod_reg[48:0];
                mul_a    = b_reg;
                mul_b    = {15'd0, pd_reg};
            end
            bto_pkg::ST_M3:
                acc_next = acc_reg + prod_reg[48:0];
            bto_pkg::ST_M4:
            begin
                mul_a = acc_reg[31:0];
                mul_b = {15'd0, disc_reg};
            end
            bto_pkg::ST_M5:
            begin
                acc2_next = prod_reg;
                mul_a     = {15'd0, acc_reg[48:32]};
                mul_b     = {15'd0, disc_reg};
            end
            bto_pkg::ST_M6:
            begin
                ram_we    = 1'b1;
                ram_wdata = node_sum[63:32];
                // upper child of the next node is the old lower child
                a_next    = b_reg;
                if (j_reg + IW'(1) != i_reg)
                    j_next = j_reg + IW'(1);
                else
                begin
                    j_next = '0;
                    i_next = i_reg - IW'(1);
                end
            end
            bto_pkg::ST_FIN:
            begin
                ram_re = 1'b1;
                i_next = '0;
            end
            bto_pkg::ST_DONE: ;
            default: ;
        endcase
        if (state_reg == bto_pkg::ST_RDA_W && i_reg == '0)
            out_next = rdata_reg;
        if (state_reg == bto_pkg::ST_LEAF_WR && j_reg == n_reg && n_reg == '0)
            i_next = IW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bto_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        strike_reg    <= strike_next;
        n_reg         <= n_next;
        pu_reg        <= pu_next;
        pd_reg        <= pd_next;
        disc_reg      <= disc_next;
        leaf_call_reg <= leaf_call_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        i_reg         <= i_next;
        p_reg         <= p_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        acc_reg       <= acc_next;
        acc2_reg      <= acc2_next;
        out_reg       <= out_next;
    end

    assign request.ready       = (state_reg == bto_pkg::ST_IDLE);
    assign result.valid        = (state_reg == bto_pkg::ST_DONE);
    assign result.option_value = out_reg;

endmodule
